/* rtl/sfl_pkg.sv */
// Shared constants, types and register codes of the symmetric FIR line filter.
package sfl_pkg;

  localparam int DATA_W       = 8;
  localparam int COEF_W       = 16;
  localparam int BANK_TAPS    = 8;
  localparam int RADIUS_W     = 4;
  localparam int RADIUS_MIN   = 2;
  localparam int MAX_RADIUS_D = 8;
  localparam int BANK_W       = 64;
  localparam int PAIR_W       = DATA_W + 1;
  localparam int PROD_W       = COEF_W + PAIR_W;
  localparam int SUM_W        = PROD_W + 3;
  localparam int FRAC_BITS    = 15;
  localparam int ADDR_W       = 5;

  localparam logic [1:0] REG_PAD_MODE  = 2'd0;
  localparam logic [1:0] REG_RADIUS    = 2'd1;
  localparam logic [1:0] REG_COEF_LOW  = 2'd2;
  localparam logic [1:0] REG_COEF_HIGH = 2'd3;

  typedef struct packed {
    logic valid;
    logic last;
  } sfl_ctl_t;

endpackage

/* rtl/sfl_seq.sv */
// Request sequencer and sample window: pushes samples and end-of-line padding.
module sfl_seq
  import sfl_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_D
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [DATA_W-1:0]                         sample,
  input  logic                                      line_last,
  input  logic                                      pad_mode,
  input  logic [RADIUS_W-1:0]                       act_r,
  input  logic                                      mac_ready,
  output logic [2*MAX_RADIUS-2:0][DATA_W-1:0]       win,
  output sfl_ctl_t                                  ctl
);

  localparam int WIN_DEPTH = 2 * MAX_RADIUS - 1;
  localparam int RAD_LIM   = (MAX_RADIUS < BANK_TAPS) ? MAX_RADIUS : BANK_TAPS;
  localparam int CNT_W     = $clog2(2 * RAD_LIM);

  logic                                 flushing;
  logic [CNT_W-1:0]                     flush_cnt;
  logic [DATA_W-1:0]                    pad_val;
  logic                                 at_start;
  logic [WIN_DEPTH-1:0][DATA_W-1:0]     win_next;
  logic [WIN_DEPTH-1:0][DATA_W-1:0]     base;
  logic [DATA_W-1:0]                    padv_in;
  logic [DATA_W-1:0]                    push_val;
  logic                                 adv;
  logic                                 take;
  logic                                 flush_push;
  logic [CNT_W-1:0]                     flush_len;

  assign adv        = !ctl.valid || mac_ready;
  assign in_stall   = flushing || !adv;
  assign take       = in_valid && !in_stall;
  assign flush_push = flushing && adv;
  assign padv_in    = pad_mode ? '0 : sample;
  assign push_val   = take ? sample : pad_val;
  assign flush_len  = CNT_W'(({1'b0, act_r} << 1) - 5'd1);

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      base[i] = (take && at_start) ? padv_in : win[i];
    end
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      win_next[i] = base[i+1];
    end
    win_next[WIN_DEPTH-1] = push_val;
  end

  always_ff @(posedge clk) begin
    if (take || flush_push) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && line_last) begin
      pad_val <= padv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing  <= 1'b0;
      flush_cnt <= '0;
      at_start  <= 1'b1;
      ctl.valid <= 1'b0;
      ctl.last  <= 1'b0;
    end else begin
      if (take || flush_push) begin
        ctl.valid <= 1'b1;
        ctl.last  <= flush_push && (flush_cnt == CNT_W'(1));
      end else if (mac_ready) begin
        ctl.valid <= 1'b0;
      end
      if (take) begin
        at_start <= line_last;
        if (line_last) begin
          flushing  <= 1'b1;
          flush_cnt <= flush_len;
        end
      end else if (flush_push) begin
        flush_cnt <= flush_cnt - CNT_W'(1);
        if (flush_cnt == CNT_W'(1)) begin
          flushing <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/sfl_mac.sv */
// Symmetric pre-add, coefficient multiply, sum, truncation and saturation.
module sfl_mac
  import sfl_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_D
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [2*MAX_RADIUS-2:0][DATA_W-1:0]   win,
  input  sfl_ctl_t                              ctl,
  input  logic [RADIUS_W-1:0]                   act_r,
  input  logic [2*BANK_W-1:0]                   coef_bank,
  output logic                                  ready,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [DATA_W-1:0]                     pixel,
  output logic                                  out_last
);

  localparam int WIN_DEPTH = 2 * MAX_RADIUS - 1;
  localparam int RAD_LIM   = (MAX_RADIUS < BANK_TAPS) ? MAX_RADIUS : BANK_TAPS;
  localparam int SHIFT_W   = SUM_W - FRAC_BITS;

  logic [RAD_LIM-1:0][PAIR_W-1:0]  pair;
  logic [RAD_LIM-1:0][COEF_W-1:0]  tap;
  logic [RAD_LIM-1:0][PROD_W-1:0]  prod;
  logic                            prod_valid;
  logic                            prod_last;
  logic [SUM_W-1:0]                sum;
  logic [SHIFT_W-1:0]              shifted;
  logic [DATA_W-1:0]               pixel_next;
  logic                            ready3;

  assign ready3 = !out_valid || !out_stall;
  assign ready  = !prod_valid || ready3;

  always_comb begin
    for (int d = 0; d < RAD_LIM; d++) begin
      pair[d] = '0;
      tap[d]  = (RADIUS_W'(d) < act_r) ? coef_bank[COEF_W*d +: COEF_W] : '0;
    end
    for (int rr = RADIUS_MIN; rr <= RAD_LIM; rr++) begin
      if (act_r == RADIUS_W'(rr)) begin
        pair[0] = {1'b0, win[WIN_DEPTH-rr]};
        for (int d = 1; d < rr; d++) begin
          pair[d] = {1'b0, win[WIN_DEPTH-rr-d]} + {1'b0, win[WIN_DEPTH-rr+d]};
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int d = 0; d < RAD_LIM; d++) begin
      sum = sum + SUM_W'(prod[d]);
    end
    shifted    = sum[SUM_W-1:FRAC_BITS];
    pixel_next = (|shifted[SHIFT_W-1:DATA_W]) ? {DATA_W{1'b1}} : shifted[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      prod_last <= ctl.last;
      for (int d = 0; d < RAD_LIM; d++) begin
        prod[d] <= PROD_W'(tap[d]) * PROD_W'(pair[d]);
      end
    end
    if (ready3) begin
      pixel    <= pixel_next;
      out_last <= prod_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ready) begin
        prod_valid <= ctl.valid;
      end
      if (ready3) begin
        out_valid <= prod_valid;
      end
    end
  end

endmodule

/* rtl/symmetric_fir_line_padded_core.sv */
// Top level of the symmetric FIR line filter with configuration registers.
// Usage:
// Samples of one image line enter on the request channel (in_valid, in_stall,
// sample, line_last); filtered pixels leave on the result channel (out_valid,
// out_stall, pixel, out_last). A request is taken when valid is high and
// stall is low.
// Each sample gives one pixel; the sample marked line_last is followed by a
// flush of 2r-1 padded pixels, the last of them marked by out_last. During
// the flush in_stall is high. Otherwise one sample is taken every cycle
// while the pipeline is not held by out_stall.
// An accepted sample passes the window register, the product register and
// the result register on its way to its pixel.
// When out_stall is high the result register holds, and the stages behind it
// fill before in_stall rises.
// Reset clears the pipeline, ends any flush, marks the next sample as a line
// start and returns the registers to pad_mode 0, radius 2 and zero taps.
// Registers are written over the APB port at byte addresses 0, 8, 16 and 24.
module symmetric_fir_line_padded_core
  import sfl_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_D
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [DATA_W-1:0]   sample,
  input  logic                line_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DATA_W-1:0]   pixel,
  output logic                out_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [BANK_W-1:0]   pwdata,
  output logic [BANK_W-1:0]   prdata,
  output logic                pready
);

  localparam int RAD_LIM = (MAX_RADIUS < BANK_TAPS) ? MAX_RADIUS : BANK_TAPS;

  logic                                 pad_mode;
  logic [RADIUS_W-1:0]                  radius;
  logic [BANK_W-1:0]                    coef_bank_low;
  logic [BANK_W-1:0]                    coef_bank_high;
  logic [RADIUS_W-1:0]                  act_r;
  logic [1:0]                           reg_idx;
  logic                                 wr_en;
  logic                                 mac_ready;
  logic [2*MAX_RADIUS-2:0][DATA_W-1:0]  win;
  sfl_ctl_t                             ctl;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    if (radius < RADIUS_W'(RADIUS_MIN)) begin
      act_r = RADIUS_W'(RADIUS_MIN);
    end else if (radius > RADIUS_W'(RAD_LIM)) begin
      act_r = RADIUS_W'(RAD_LIM);
    end else begin
      act_r = radius;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_mode       <= 1'b0;
      radius         <= RADIUS_W'(RADIUS_MIN);
      coef_bank_low  <= '0;
      coef_bank_high <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAD_MODE:  pad_mode       <= pwdata[0];
        REG_RADIUS:    radius         <= pwdata[RADIUS_W-1:0];
        REG_COEF_LOW:  coef_bank_low  <= pwdata;
        REG_COEF_HIGH: coef_bank_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAD_MODE:  prdata = BANK_W'(pad_mode);
      REG_RADIUS:    prdata = BANK_W'(radius);
      REG_COEF_LOW:  prdata = coef_bank_low;
      REG_COEF_HIGH: prdata = coef_bank_high;
      default:       prdata = '0;
    endcase
  end

  sfl_seq #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .line_last (line_last),
    .pad_mode  (pad_mode),
    .act_r     (act_r),
    .mac_ready (mac_ready),
    .win       (win),
    .ctl       (ctl)
  );

  sfl_mac #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .ctl       (ctl),
    .act_r     (act_r),
    .coef_bank ({coef_bank_high, coef_bank_low}),
    .ready     (mac_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel     (pixel),
    .out_last  (out_last)
  );

endmodule

/* dv/sfl_line_checker.sv */
// Watches the symmetric FIR line filter's channels and register port, predicts and checks pixels.
module sfl_line_checker
  import sfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [DATA_W-1:0] sample,
  input  logic              line_last,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [DATA_W-1:0] pixel,
  input  logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [BANK_W-1:0] pwdata,
  output int                errors,
  output int                pending,
  output int                checked
);

  localparam int WIN_DEPTH = 2 * MAX_RADIUS_D - 1;

  typedef struct packed {
    logic [DATA_W-1:0] pixel;
    logic              last;
  } pixel_t;

  logic              pad_zero;
  logic [RADIUS_W-1:0] radius_q;
  logic [BANK_W-1:0] coef_lo;
  logic [BANK_W-1:0] coef_hi;
  logic [DATA_W-1:0] win [WIN_DEPTH];
  logic              at_start;
  pixel_t            pixel_q [$];

  function automatic int unsigned eff_radius();
    int unsigned r;
    r = radius_q;
    if (r < RADIUS_MIN) r = RADIUS_MIN;
    if (r > MAX_RADIUS_D) r = MAX_RADIUS_D;
    if (r > BANK_TAPS) r = BANK_TAPS;
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] tap_at(int unsigned d);
    if (d < 4) return coef_lo[16*d +: 16];
    if (d < 8) return coef_hi[16*(d-4) +: 16];
    return '0;
  endfunction

  function automatic logic [DATA_W-1:0] filter_point();
    int unsigned r;
    int unsigned len;
    int unsigned base;
    int unsigned d;
    logic [63:0] acc;
    r = eff_radius();
    len = 2 * r - 1;
    base = WIN_DEPTH - len;
    acc = '0;
    for (int unsigned j = 0; j < len; j++) begin
      d = (j < r - 1) ? (r - 1 - j) : (j - (r - 1));
      acc += 64'(tap_at(d)) * 64'(win[base + j]);
    end
    acc = acc >> FRAC_BITS;
    return (acc > 64'd255) ? 8'hFF : acc[7:0];
  endfunction

  task automatic shift_in(input logic [DATA_W-1:0] v);
    for (int i = 0; i < WIN_DEPTH - 1; i++) win[i] = win[i + 1];
    win[WIN_DEPTH - 1] = v;
  endtask

  task automatic take_sample(input logic [DATA_W-1:0] s, input logic l);
    logic [DATA_W-1:0] padv;
    int unsigned nflush;
    pixel_t p;
    padv = pad_zero ? '0 : s;
    if (at_start) begin
      for (int i = 0; i < WIN_DEPTH; i++) win[i] = padv;
    end
    shift_in(s);
    p.pixel = filter_point();
    p.last = 1'b0;
    pixel_q.push_back(p);
    if (l) begin
      nflush = 2 * eff_radius() - 1;
      for (int unsigned i = 0; i < nflush; i++) begin
        shift_in(padv);
        p.pixel = filter_point();
        p.last = (i == nflush - 1);
        pixel_q.push_back(p);
      end
      at_start = 1'b1;
    end else begin
      at_start = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      pad_zero = 1'b0;
      radius_q = RADIUS_W'(RADIUS_MIN);
      coef_lo = '0;
      coef_hi = '0;
      for (int i = 0; i < WIN_DEPTH; i++) win[i] = '0;
      at_start = 1'b1;
      pixel_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel %0d last %0b with nothing expected",
                   $time, pixel, out_last);
        end else begin
          e = pixel_q.pop_front();
          if (pixel !== e.pixel || out_last !== e.last) begin
            errors++;
            $display("%0t: mismatch, expected pixel %0d last %0b, got pixel %0d last %0b",
                     $time, e.pixel, e.last, pixel, out_last);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:3])
          REG_PAD_MODE:  pad_zero = pwdata[0];
          REG_RADIUS:    radius_q = pwdata[RADIUS_W-1:0];
          REG_COEF_LOW:  coef_lo = pwdata;
          REG_COEF_HIGH: coef_hi = pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_sample(sample, line_last);
    end
    pending = pixel_q.size();
  end

endmodule

/* dv/symmetric_fir_line_padded_core_tb.sv */
// Testbench top: drives lines and register writes into the FIR line filter and reports the verdict.
module symmetric_fir_line_padded_core_tb;
  import sfl_pkg::*;

  localparam int unsigned LIMIT = 500000;
  localparam int PHASE_ITEMS = 103;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] sample = '0;
  logic              line_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] pixel;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [BANK_W-1:0] pwdata = '0;
  logic [BANK_W-1:0] prdata;
  logic              pready;

  int          errors;
  int          pending;
  int          checked;
  int unsigned cycles = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          n_items = 0;
  int          n_lines = 0;

  symmetric_fir_line_padded_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .line_last(line_last),
    .out_valid(out_valid), .out_stall(out_stall), .pixel(pixel), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sfl_line_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .line_last(line_last),
    .out_valid(out_valid), .out_stall(out_stall), .pixel(pixel), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending), .checked(checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < out_idle_pct);

  initial begin
    wait (cycles >= LIMIT);
    $display("%0t: timeout with %0d pixels still expected", $time, pending);
    $display("status: fail");
    $finish;
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [BANK_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_req(input logic [DATA_W-1:0] s, input logic l);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    line_last <= l;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_items++;
  endtask

  task automatic end_line();
    in_valid <= 1'b0;
    @(negedge clk);
    n_lines++;
  endtask

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 6))
      0: return 8'h00;
      1: return 8'hFF;
      default: return DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [BANK_W-1:0] pick_bank();
    logic [BANK_W-1:0] b;
    case ($urandom_range(0, 5))
      0: b = '0;
      1: b = '1;
      2: b = {$urandom, $urandom};
      default: begin
        for (int k = 0; k < 4; k++) b[16*k +: 16] = 16'($urandom_range(0, 4096));
      end
    endcase
    return b;
  endfunction

  function automatic logic [BANK_W-1:0] pick_radius();
    if ($urandom_range(0, 3) == 0) return BANK_W'($urandom_range(0, 15));
    return BANK_W'($urandom_range(2, 8));
  endfunction

  task automatic send_line(input int len);
    for (int i = 0; i < len; i++) send_req(pick_sample(), i == len - 1);
    end_line();
  endtask

  task automatic rand_cfg_one();
    case ($urandom_range(0, 3))
      0: cfg_write(REG_PAD_MODE, BANK_W'($urandom_range(0, 1)));
      1: cfg_write(REG_RADIUS, pick_radius());
      2: cfg_write(REG_COEF_LOW, pick_bank());
      default: cfg_write(REG_COEF_HIGH, pick_bank());
    endcase
  endtask

  initial begin
    int len;
    int start;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values: zero taps give zero pixels; a one-sample line.
    send_req(8'hA5, 1'b1);
    end_line();
    drain();

    // All taps at full scale, radius above range, edge padding: saturation.
    cfg_write(REG_COEF_LOW, '1);
    cfg_write(REG_COEF_HIGH, '1);
    cfg_write(REG_RADIUS, 64'd15);
    cfg_write(REG_PAD_MODE, 64'd0);
    send_req(8'hFF, 1'b1);
    end_line();
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b1);
    end_line();
    drain();

    // Radius below range with a unity center tap and zero padding.
    cfg_write(REG_RADIUS, 64'd1);
    cfg_write(REG_PAD_MODE, 64'd1);
    cfg_write(REG_COEF_LOW, 64'h0000_0000_4000_8000);
    send_req(8'd1, 1'b0);
    send_req(8'd2, 1'b0);
    send_req(8'd128, 1'b0);
    send_req(8'd255, 1'b0);
    send_req(8'd0, 1'b1);
    end_line();
    drain();

    // Largest radius with small taps, zero padding.
    cfg_write(REG_RADIUS, 64'd8);
    cfg_write(REG_COEF_LOW, {4{16'h0800}});
    cfg_write(REG_COEF_HIGH, {4{16'h0800}});
    send_req(8'hFF, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b1);
    end_line();
    drain();

    cfg_write(REG_RADIUS, 64'd9);
    cfg_write(REG_PAD_MODE, 64'd0);
    send_req(8'd200, 1'b1);
    end_line();
    drain();

    // Small radius: the high bank must not contribute.
    cfg_write(REG_RADIUS, 64'd3);
    cfg_write(REG_COEF_LOW, 64'h0000_1000_2000_3000);
    cfg_write(REG_COEF_HIGH, {$urandom, $urandom});
    send_line(6);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
        1: begin in_idle_pct = 78; out_idle_pct = 0;  end
        2: begin in_idle_pct = 0;  out_idle_pct = 78; end
        default: begin in_idle_pct = 12; out_idle_pct = 12; end
      endcase
      drain();
      cfg_write(REG_PAD_MODE, BANK_W'(ph & 1));
      cfg_write(REG_RADIUS, pick_radius());
      cfg_write(REG_COEF_LOW, pick_bank());
      cfg_write(REG_COEF_HIGH, pick_bank());
      start = n_items;
      while (n_items - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          drain();
          rand_cfg_one();
        end
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_line(len);
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Covered %0d samples in %0d lines, %0d pixels compared, %0d errors.",
             n_items, n_lines, checked, errors);
    $display("Both pad modes, radius 0..15 with clamping, and four stall mixes were run.");
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* symmetric_fir_line_padded_core.f */
rtl/sfl_pkg.sv
rtl/sfl_seq.sv
rtl/sfl_mac.sv
rtl/symmetric_fir_line_padded_core.sv
dv/sfl_line_checker.sv
dv/symmetric_fir_line_padded_core_tb.sv
